// File: hw/rtl/pgat_pkg.sv
// Package: shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package pgat_pkg;
  localparam int GridDim         = 8;
  localparam int BinW            = $clog2(GridDim);
  localparam int CellW           = 2 * BinW;
  localparam int Cells           = GridDim * GridDim;
  localparam int HistoryDepthDef = 4;
  localparam int CycleSpan       = 4;
  localparam int EmaW            = 24;
  localparam int CntW            = 32;
  localparam int TotW            = 40;
  localparam int OneQ16          = 65536;

  localparam logic [2:0] RegEmaAlpha  = 3'd0;
  localparam logic [2:0] RegLevelMin  = 3'd1;
  localparam logic [2:0] RegLevelMax  = 3'd2;
  localparam logic [2:0] RegRateMin   = 3'd3;
  localparam logic [2:0] RegRateMax   = 3'd4;
  localparam logic [2:0] RegMinTotal  = 3'd5;
  localparam logic [2:0] RegThreshold = 3'd6;

  typedef struct packed {
    logic load;       // capture sample, run EMA
    logic bin_start;  // start both binning dividers
    logic update;     // write count, peak, history, counters
    logic judge;      // evaluate attractor, present result
    logic clr_wr;     // clearing sweep write
  } pgat_cmd_t;

  typedef struct packed {
    logic bin_done;
  } pgat_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/phase_grid_attractor_tracker.sv
// Sequencing: after a sample transfer the controller loads the EMA, starts both binning
// dividers, waits for both, reads and updates the histogram, judges, then raises m_axis_tvalid.
// A new sample is taken only after the previous result has been accepted; the
// binning dividers (one quotient bit per cycle) and the histogram read-modify-write set the pace.
// Reset: asynchronous, active low; afterwards a clearing sweep writes zero to each
// histogram cell in turn while no sample is taken (config writes accepted).
`timescale 1ns / 1ps
`default_nettype none
module phase_grid_attractor_tracker
  import pgat_pkg::*;
#(
  parameter int HistoryDepth = HistoryDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] cell_row, [5:3] cell_col, [6] attractor_valid, [9:7] attr_row,
  // [12:10] attr_col, [13] attractor_moved, [14] cyc_found,
  // [20:15] cycle_cell_a, [26:21] cycle_cell_b, [58:27] transition_count,
  // [90:59] record_count, [95:91] zero
  output logic [95:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);
  logic [16:0] alpha_q, thr_q;
  logic signed [15:0] lmin_q, lmax_q;
  logic signed [16:0] rmin_q, rmax_q;
  logic [15:0] mtot_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 17'd6554;
      lmin_q  <= -16'sd16384;
      lmax_q  <= 16'sd16384;
      rmin_q  <= -17'sd8192;
      rmax_q  <= 17'sd8192;
      mtot_q  <= 16'd10;
      thr_q   <= 17'd19661;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEmaAlpha:  alpha_q <= cfg_data_i;
        RegLevelMin:  lmin_q  <= cfg_data_i[15:0];
        RegLevelMax:  lmax_q  <= cfg_data_i[15:0];
        RegRateMin:   rmin_q  <= cfg_data_i;
        RegRateMax:   rmax_q  <= cfg_data_i;
        RegMinTotal:  mtot_q  <= cfg_data_i[15:0];
        RegThreshold: thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pgat_cmd_t cmd;
  pgat_sts_t sts;
  logic [CellW-1:0] clr_addr;

  pgat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .clr_addr_o(clr_addr));

  logic [BinW-1:0] crow, ccol, arow, acol;
  logic [CellW-1:0] cya, cyb;
  logic av, am, cf;
  logic [CntW-1:0] tc, rc;

  pgat_datapath #(.HistoryDepth(HistoryDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .clr_addr_i(clr_addr),
    .sample_i(s_axis_tdata), .ema_alpha_i(alpha_q), .level_min_i(lmin_q),
    .level_max_i(lmax_q), .rate_min_i(rmin_q), .rate_max_i(rmax_q),
    .min_total_i(mtot_q), .threshold_i(thr_q),
    .cell_row_o(crow), .cell_col_o(ccol), .attractor_valid_o(av),
    .attr_row_o(arow), .attr_col_o(acol), .attractor_moved_o(am),
    .cyc_found_o(cf), .cycle_cell_a_o(cya), .cycle_cell_b_o(cyb),
    .transition_count_o(tc), .record_count_o(rc));

  assign m_axis_tdata = {5'd0, rc, tc, 6'(cyb), 6'(cya), cf, am,
                         3'(acol), 3'(arow), av, 3'(ccol), 3'(crow)};
endmodule
`default_nettype wire

// File: hw/rtl/pgat_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pgat_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/pgat_binner.sv
// Iterative binning unit: floor((v-lo)*GRID/(hi-lo)) clamped, restoring division.
`timescale 1ns / 1ps
`default_nettype none
module pgat_binner
  import pgat_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic signed [26:0] v_i,
  input  wire logic signed [26:0] lo_i,
  input  wire logic signed [26:0] hi_i,
  output logic                 done_o,
  output logic [BinW-1:0]      bin_o
);
  localparam int SpanW = 28;
  localparam int NumW  = SpanW + BinW;

  logic [SpanW-1:0] span_q, span_d;
  logic [NumW-1:0]  rem_q, rem_d;
  logic [BinW-1:0]  quo_q, quo_d;
  logic [$clog2(BinW+1)-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic signed [SpanW-1:0] span_s, num_s;
  logic [NumW-1:0] trial;
  logic [NumW-1:0] shifted;

  always_comb begin
    span_s  = SpanW'(hi_i) - SpanW'(lo_i);
    num_s   = SpanW'(v_i) - SpanW'(lo_i);
    span_d  = span_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    // hold done until the next start
    done_d  = done_q;
    shifted = '0;
    trial   = '0;
    if (start_i) begin
      if (span_s <= 0 || num_s < 0) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (num_s >= span_s) begin
        quo_d  = BinW'(GridDim - 1);
        done_d = 1'b1;
      end else begin
        span_d = span_s;
        rem_d  = NumW'(num_s);
        quo_d  = '0;
        cnt_d  = '0;
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      // one quotient bit per cycle: rem*2 against span
      shifted = rem_q << 1;
      trial   = shifted - NumW'(span_q);
      if (shifted >= NumW'(span_q)) begin
        rem_d = trial;
        quo_d = {quo_q[BinW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[BinW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(BinW+1))'(BinW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign bin_o  = quo_q;
endmodule
`default_nettype wire

// File: hw/rtl/pgat_datapath.sv
// Datapath: EMA, binning, histogram RAM, peak, history, counters and attractor.
`timescale 1ns / 1ps
`default_nettype none
module pgat_datapath
  import pgat_pkg::*;
#(
  parameter int HistoryDepth = HistoryDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pgat_cmd_t         cmd_i,
  output pgat_sts_t              sts_o,
  input  wire logic [CellW-1:0]  clr_addr_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic [16:0]       ema_alpha_i,
  input  wire logic signed [15:0] level_min_i,
  input  wire logic signed [15:0] level_max_i,
  input  wire logic signed [16:0] rate_min_i,
  input  wire logic signed [16:0] rate_max_i,
  input  wire logic [15:0]       min_total_i,
  input  wire logic [16:0]       threshold_i,
  output logic [BinW-1:0]        cell_row_o,
  output logic [BinW-1:0]        cell_col_o,
  output logic                   attractor_valid_o,
  output logic [BinW-1:0]        attr_row_o,
  output logic [BinW-1:0]        attr_col_o,
  output logic                   attractor_moved_o,
  output logic                   cyc_found_o,
  output logic [CellW-1:0]       cycle_cell_a_o,
  output logic [CellW-1:0]       cycle_cell_b_o,
  output logic [CntW-1:0]        transition_count_o,
  output logic [CntW-1:0]        record_count_o
);
  localparam logic [CntW-1:0] Sat = '1;
  localparam logic [CntW-1:0] ZeroCnt = '0;

  logic signed [EmaW-1:0] ema_q, ema_d, prev_q;
  logic seeded_q;
  logic signed [EmaW-1:0] s22;
  logic signed [EmaW:0]   diff;
  logic signed [EmaW+17:0] prod;
  logic signed [EmaW+17:0] rnd;
  logic [16:0] alpha;

  always_comb begin
    s22   = {sample_i, 8'd0};
    alpha = (ema_alpha_i > 17'(OneQ16)) ? 17'(OneQ16) : ema_alpha_i;
    diff  = (EmaW+1)'(s22) - (EmaW+1)'(ema_q);
    prod  = (EmaW+18)'(diff) * $signed({1'b0, alpha});
    // arithmetic shift of p+2^15 equals the round-half-up floor
    rnd   = (prod + (EmaW+18)'(32768)) >>> 16;
    ema_d = seeded_q ? ema_q + EmaW'(rnd) : s22;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q    <= '0;
      prev_q   <= '0;
      seeded_q <= 1'b0;
    end else if (cmd_i.load) begin
      prev_q   <= seeded_q ? ema_q : s22;
      ema_q    <= ema_d;
      seeded_q <= 1'b1;
    end
  end

  logic signed [26:0] vel, lmin, lmax, rmin, rmax;
  assign vel  = 27'(ema_q) - 27'(prev_q);
  assign lmin = {{3{level_min_i[15]}}, level_min_i, 8'd0};
  assign lmax = {{3{level_max_i[15]}}, level_max_i, 8'd0};
  assign rmin = {{2{rate_min_i[16]}}, rate_min_i, 8'd0};
  assign rmax = {{2{rate_max_i[16]}}, rate_max_i, 8'd0};

  logic row_done, col_done, bins_done;
  logic [BinW-1:0] row_bin, col_bin;
  pgat_binner u_row (
    .clk_i, .rst_ni, .start_i(cmd_i.bin_start), .v_i(27'(ema_q)),
    .lo_i(lmin), .hi_i(lmax), .done_o(row_done), .bin_o(row_bin));
  pgat_binner u_col (
    .clk_i, .rst_ni, .start_i(cmd_i.bin_start), .v_i(vel),
    .lo_i(rmin), .hi_i(rmax), .done_o(col_done), .bin_o(col_bin));
  // a clamped axis finishes early: wait for both
  assign bins_done      = row_done & col_done;
  assign sts_o.bin_done = bins_done;

  logic [CellW-1:0] cell_q;
  always_ff @(posedge clk_i) begin
    if (bins_done) begin
      cell_q <= {row_bin, col_bin};
    end
  end

  logic [CntW-1:0] rd_cnt, new_cnt;
  logic            ram_we;
  logic [CellW-1:0] ram_waddr;
  logic [CntW-1:0] ram_wdata;
  assign new_cnt   = (rd_cnt == Sat) ? rd_cnt : rd_cnt + 1'b1;
  assign ram_we    = cmd_i.update | cmd_i.clr_wr;
  assign ram_waddr = cmd_i.clr_wr ? clr_addr_i : cell_q;
  assign ram_wdata = cmd_i.clr_wr ? ZeroCnt : new_cnt;
  pgat_ram #(.Width(CntW), .Depth(Cells)) u_hist (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(cell_q), .rdata_o(rd_cnt));

  logic [CntW-1:0] peak_cnt_q, trans_q, rec_q;
  logic [CellW-1:0] peak_cell_q, cur_q, attr_cell_q;
  logic attr_set_q, moved_q, cyc_q;
  logic [TotW-1:0] total_q;
  logic [CellW-1:0] hist_q [HistoryDepth];
  logic [$clog2(HistoryDepth+1)-1:0] fill_q;
  logic [CellW-1:0] ca_q, cb_q;
  logic [BinW-1:0] row_q, col_q;

  logic [TotW+17:0] lhs, rhs;
  logic take;
  assign lhs  = (TotW+18)'(peak_cnt_q) << 16;
  assign rhs  = (TotW+18)'(threshold_i) * (TotW+18)'(total_q);
  assign take = (total_q != '0) && (total_q >= TotW'(min_total_i)) && (lhs >= rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_cnt_q  <= '0;
      peak_cell_q <= '0;
      cur_q       <= '0;
      attr_cell_q <= '0;
      attr_set_q  <= 1'b0;
      moved_q     <= 1'b0;
      cyc_q       <= 1'b0;
      trans_q     <= '0;
      rec_q       <= '0;
      total_q     <= '0;
      fill_q      <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      for (int i = 0; i < HistoryDepth; i++) hist_q[i] <= '0;
    end else begin
      if (cmd_i.update) begin
        if (new_cnt > peak_cnt_q ||
            (new_cnt == peak_cnt_q && cell_q < peak_cell_q)) begin
          peak_cnt_q  <= new_cnt;
          peak_cell_q <= cell_q;
        end
        if (rd_cnt != Sat) total_q <= total_q + 1'b1;
        hist_q[0] <= cell_q;
        for (int i = 1; i < HistoryDepth; i++) hist_q[i] <= hist_q[i-1];
        if (fill_q < ($clog2(HistoryDepth+1))'(HistoryDepth)) fill_q <= fill_q + 1'b1;
        if (cell_q != cur_q && rec_q != '0 && trans_q != Sat) trans_q <= trans_q + 1'b1;
        cur_q <= cell_q;
        if (rec_q != Sat) rec_q <= rec_q + 1'b1;
        row_q <= cell_q[CellW-1:BinW];
        col_q <= cell_q[BinW-1:0];
      end
      if (cmd_i.judge) begin
        moved_q <= take && attr_set_q && (attr_cell_q != peak_cell_q);
        if (take) begin
          attr_cell_q <= peak_cell_q;
          attr_set_q  <= 1'b1;
        end
        if (fill_q >= ($clog2(HistoryDepth+1))'(CycleSpan) && hist_q[0] != hist_q[1]
            && hist_q[0] == hist_q[2] && hist_q[1] == hist_q[3]) begin
          cyc_q <= 1'b1;
          ca_q  <= hist_q[0];
          cb_q  <= hist_q[1];
        end else begin
          cyc_q <= 1'b0;
          ca_q  <= '0;
          cb_q  <= '0;
        end
      end
    end
  end

  assign cell_row_o         = row_q;
  assign cell_col_o         = col_q;
  assign attractor_valid_o  = attr_set_q;
  assign attr_row_o         = attr_set_q ? attr_cell_q[CellW-1:BinW] : '0;
  assign attr_col_o         = attr_set_q ? attr_cell_q[BinW-1:0] : '0;
  assign attractor_moved_o  = moved_q;
  assign cyc_found_o        = cyc_q;
  assign cycle_cell_a_o     = ca_q;
  assign cycle_cell_b_o     = cb_q;
  assign transition_count_o = trans_q;
  assign record_count_o     = rec_q;
endmodule
`default_nettype wire

// File: hw/rtl/pgat_ctrl.sv
// Controller: clearing sweep, then per-sample sequencing and output handshake.
`timescale 1ns / 1ps
`default_nettype none
module pgat_ctrl
  import pgat_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire pgat_sts_t        sts_i,
  output pgat_cmd_t             cmd_o,
  output logic [CellW-1:0]      clr_addr_o
);
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StBin   = 3'd2;
  localparam logic [2:0] StWait  = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StUpd   = 3'd5;
  localparam logic [2:0] StJudge = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [CellW-1:0] clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StBin;
        end
      end
      StBin: begin
        cmd_o.bin_start = 1'b1;
        state_d = StWait;
      end
      StWait: if (sts_i.bin_done) state_d = StRead;
      // wait for histogram read data
      StRead: state_d = StUpd;
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d = StJudge;
      end
      StJudge: begin
        cmd_o.judge = 1'b1;
        state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign clr_addr_o  = clr_q;
endmodule
`default_nettype wire

// File: hw/rtl/pgat_checker.sv
// Port-level checker for the tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pgat_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken with result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  // the count advances in the update state, before the judge state and the result
  a_rec_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && $past(m_axis_tdata[90:59], 2) != 32'hFFFFFFFF
    |-> m_axis_tdata[90:59] != $past(m_axis_tdata[90:59], 2))
    else $error("record count did not advance");
  a_attr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[12:7] == 6'd0)
    else $error("attractor cell non-zero while not valid");
endmodule

bind phase_grid_attractor_tracker pgat_checker u_pgat_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
`default_nettype wire
